// ===== rtl/longest_prefix_route_lookup_macros.svh =====
// Assertion macros used by the route lookup checker.
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_MACROS_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define LPRL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define LPRL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lprl_pkg.sv =====
// Types and constants for the longest-prefix route lookup.
package lprl_pkg;

   localparam int unsigned AddrBits  = 32;
   localparam int unsigned SlotBits  = 4;
   localparam int unsigned IfaceBits = 8;
   localparam int unsigned OpBits    = 2;

   // req_tdata layout, lowest bit first
   localparam int unsigned SlotLsb    = 0;
   localparam int unsigned PrefixLsb  = SlotLsb + SlotBits;
   localparam int unsigned MaskLsb    = PrefixLsb + AddrBits;
   localparam int unsigned GwLsb      = MaskLsb + AddrBits;
   localparam int unsigned IfaceLsb   = GwLsb + AddrBits;
   localparam int unsigned LookupLsb  = IfaceLsb + IfaceBits;
   localparam int unsigned ReqUsed    = LookupLsb + AddrBits;
   localparam int unsigned ReqBits    = ((ReqUsed + 7) / 8) * 8;

   // rsp_tdata layout, lowest bit first
   localparam int unsigned RspBits    = ((AddrBits + IfaceBits + 7) / 8) * 8;

   typedef enum logic [OpBits-1:0] {
      OP_WRITE  = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   // One item moving down the cell chain, with the best match seen so far.
   typedef struct packed {
      logic                 valid;
      op_type               op;
      logic [SlotBits-1:0]  slot;
      logic [AddrBits-1:0]  prefix;
      logic [AddrBits-1:0]  netmask;
      logic [AddrBits-1:0]  gateway;
      logic [IfaceBits-1:0] iface;
      logic [AddrBits-1:0]  addr;
      logic                 hit;
      logic [AddrBits-1:0]  best_mask;
      logic [AddrBits-1:0]  hop;
      logic [IfaceBits-1:0] port;
   } beat_type;

endpackage

// ===== rtl/longest_prefix_route_lookup.sv =====
// Top level of the longest-prefix route lookup table.
//
// IPv4 routing table of NUM_ROUTES slots built as a chain of cells, one cell
// per slot. Every request beat (write, clear or lookup, selected by req_tuser)
// walks down the chain one cell per cycle. A cell applies a write or clear
// aimed at its own slot, and on a lookup it compares the address against its
// route under the route's mask; the running best match (largest mask, ties to
// the lower slot) travels with the beat. Since all beats move in lockstep, a
// lookup sees exactly the writes and clears accepted before it. Throughput is
// one request beat per cycle while the chain is not stalled; a lookup's response
// beat shows on rsp_tvalid after passing one register per cell (the first
// loading at the accepting edge) and then the output register. Writes,
// clears and the unused op code give no response. The whole chain stalls while
// a response waits in the output register, so req_tready follows rsp_tready.
// A lookup with no match returns found = 0 with zero next hop and interface.
// Only the low IFACE_BITS bits of a written interface are kept. All slots
// come out of reset invalid.
module longest_prefix_route_lookup #(
   parameter int unsigned NUM_ROUTES = 16,
   parameter int unsigned IFACE_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // slot[3:0], prefix[35:4], netmask[67:36], gateway[99:68],
   // iface[107:100], lookup_address[139:108], zero pad[143:140]
   input  logic [lprl_pkg::ReqBits-1:0] req_tdata,
   // op[1:0]
   input  logic [lprl_pkg::OpBits-1:0]  req_tuser,
   // response channel
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // next_hop[31:0], out_interface[39:32]
   output logic [lprl_pkg::RspBits-1:0] rsp_tdata,
   // found[0]
   output logic                         rsp_tuser
);

   lprl_pkg::beat_type chain [NUM_ROUTES+1];

   logic                           advance;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic                           rsp_found_ff;
   logic [lprl_pkg::AddrBits-1:0]  rsp_hop_ff;
   logic [lprl_pkg::IfaceBits-1:0] rsp_port_ff;

   // chain moves whenever the output register is free or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // head of the chain: unpack the request beat, no match yet
   always_comb begin
      chain[0].valid     = req_tvalid;
      chain[0].op        = lprl_pkg::op_type'(req_tuser);
      chain[0].slot      = req_tdata[lprl_pkg::SlotLsb +: lprl_pkg::SlotBits];
      chain[0].prefix    = req_tdata[lprl_pkg::PrefixLsb +: lprl_pkg::AddrBits];
      chain[0].netmask   = req_tdata[lprl_pkg::MaskLsb +: lprl_pkg::AddrBits];
      chain[0].gateway   = req_tdata[lprl_pkg::GwLsb +: lprl_pkg::AddrBits];
      chain[0].iface     = req_tdata[lprl_pkg::IfaceLsb +: lprl_pkg::IfaceBits];
      chain[0].addr      = req_tdata[lprl_pkg::LookupLsb +: lprl_pkg::AddrBits];
      chain[0].hit       = 1'b0;
      chain[0].best_mask = '0;
      chain[0].hop       = '0;
      chain[0].port      = '0;
   end

   for (genvar i = 0; i < NUM_ROUTES; i++) begin : g_cell
      lprl_cell #(
         .CELL_INDEX (i),
         .IFACE_BITS (IFACE_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .beat_in  (chain[i]),
         .beat_out (chain[i+1])
      );
   end

   // only lookups leaving the chain become responses
   assign rsp_valid_in = chain[NUM_ROUTES].valid &&
                         (chain[NUM_ROUTES].op == lprl_pkg::OP_LOOKUP);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_found_ff <= chain[NUM_ROUTES].hit;
         rsp_hop_ff   <= chain[NUM_ROUTES].hop;
         rsp_port_ff  <= chain[NUM_ROUTES].port;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = lprl_pkg::RspBits'({rsp_port_ff, rsp_hop_ff});

endmodule

// ===== rtl/lprl_cell.sv =====
// One route slot of the lookup chain: holds a route and updates passing beats.
module lprl_cell #(
   parameter int unsigned CELL_INDEX = 0,
   parameter int unsigned IFACE_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  lprl_pkg::beat_type beat_in,
   output lprl_pkg::beat_type beat_out
);

   localparam int unsigned StoreBits =
      (IFACE_BITS < lprl_pkg::IfaceBits) ? IFACE_BITS : lprl_pkg::IfaceBits;

   logic                                route_valid_ff;
   logic                                route_valid_in;
   logic [lprl_pkg::AddrBits-1:0]       route_prefix_ff;
   logic [lprl_pkg::AddrBits-1:0]       route_mask_ff;
   logic [lprl_pkg::AddrBits-1:0]       route_gateway_ff;
   logic [StoreBits-1:0]                route_iface_ff;
   lprl_pkg::beat_type                  beat_ff;
   lprl_pkg::beat_type                  beat_in_next;
   logic                                slot_sel;
   logic                                do_write;
   logic                                match;
   logic                                better;

   assign slot_sel = (32'(beat_in.slot) == CELL_INDEX);
   assign do_write = advance && beat_in.valid && slot_sel && (beat_in.op == lprl_pkg::OP_WRITE);

   assign match  = route_valid_ff &&
                   ((route_prefix_ff & route_mask_ff) == (beat_in.addr & route_mask_ff));
   // strict compare keeps ties with the earlier (lower) slot
   assign better = match && (!beat_in.hit || (route_mask_ff > beat_in.best_mask));

   always_comb begin
      route_valid_in = route_valid_ff;
      if (advance && beat_in.valid && slot_sel) begin
         unique case (beat_in.op)
            lprl_pkg::OP_WRITE:  route_valid_in = 1'b1;
            lprl_pkg::OP_CLEAR:  route_valid_in = 1'b0;
            default:             route_valid_in = route_valid_ff;
         endcase
      end
   end

   always_comb begin
      beat_in_next = beat_in;
      if (beat_in.op == lprl_pkg::OP_LOOKUP && better) begin
         beat_in_next.hit       = 1'b1;
         beat_in_next.best_mask = route_mask_ff;
         beat_in_next.hop       = route_gateway_ff;
         beat_in_next.port      = lprl_pkg::IfaceBits'(route_iface_ff);
      end
   end

   // valid bits reset; route and beat payload only load
   always_ff @(posedge clock) begin
      if (reset) begin
         route_valid_ff <= 1'b0;
         beat_ff.valid  <= 1'b0;
      end else begin
         route_valid_ff <= route_valid_in;
         if (advance) begin
            beat_ff.valid <= beat_in_next.valid;
         end
      end
      if (do_write) begin
         route_prefix_ff  <= beat_in.prefix;
         route_mask_ff    <= beat_in.netmask;
         route_gateway_ff <= beat_in.gateway;
         route_iface_ff   <= beat_in.iface[StoreBits-1:0];
      end
      if (advance) begin
         beat_ff.op        <= beat_in_next.op;
         beat_ff.slot      <= beat_in_next.slot;
         beat_ff.prefix    <= beat_in_next.prefix;
         beat_ff.netmask   <= beat_in_next.netmask;
         beat_ff.gateway   <= beat_in_next.gateway;
         beat_ff.iface     <= beat_in_next.iface;
         beat_ff.addr      <= beat_in_next.addr;
         beat_ff.hit       <= beat_in_next.hit;
         beat_ff.best_mask <= beat_in_next.best_mask;
         beat_ff.hop       <= beat_in_next.hop;
         beat_ff.port      <= beat_in_next.port;
      end
   end

   assign beat_out = beat_ff;

endmodule

// ===== rtl/lprl_chk.sv =====
// Port-level checks for the route lookup, bound to the top level.
`include "longest_prefix_route_lookup_macros.svh"

module lprl_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [lprl_pkg::RspBits-1:0] rsp_tdata,
   input logic                         rsp_tuser
);

   // held response keeps its payload
   `LPRL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")

   // a miss carries zero next hop and interface
   `LPRL_ASSERT_NOW(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "miss with nonzero payload")

   // chain stalls while a response is blocked
   `LPRL_ASSERT_NOW(a_stall, clock, reset, rsp_tvalid && !rsp_tready, !req_tready, "request taken while output blocked")

   // no response right after reset
   `LPRL_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid, "response valid after reset")

endmodule

bind longest_prefix_route_lookup lprl_chk u_lprl_chk (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for the longest-prefix route lookup table.
module tb_top;

   // op code 3 is not in the package enum; the block must drop such beats
   localparam logic [lprl_pkg::OpBits-1:0] OpReserved = 2'd3;

   localparam int NumSlots    = 16;
   localparam int ItemCount   = 1250;
   localparam int TailItems   = 150;   // last beats go out with no idling
   localparam int HoldAfter   = 250;   // responses before the long back-pressure
   localparam int HoldCycles  = 300;
   localparam int DrainCycles = 40;    // chain depth is NUM_ROUTES + 1
   localparam int StallLimit  = 5000;
   localparam int ReportLimit = 10;

   typedef struct {
      logic [lprl_pkg::OpBits-1:0]    op;
      logic [lprl_pkg::SlotBits-1:0]  slot;
      logic [lprl_pkg::AddrBits-1:0]  prefix;
      logic [lprl_pkg::AddrBits-1:0]  netmask;
      logic [lprl_pkg::AddrBits-1:0]  gateway;
      logic [lprl_pkg::IfaceBits-1:0] iface;
      logic [lprl_pkg::AddrBits-1:0]  addr;
   } route_req_type;

   typedef struct {
      logic                           found;
      logic [lprl_pkg::AddrBits-1:0]  next_hop;
      logic [lprl_pkg::IfaceBits-1:0] out_interface;
   } route_answer_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [lprl_pkg::ReqBits-1:0]   req_tdata = '0;
   logic [lprl_pkg::OpBits-1:0]    req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [lprl_pkg::RspBits-1:0]   rsp_tdata;
   logic                           rsp_tuser;

   longest_prefix_route_lookup DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Route table predictor: own copy of the table, updated per accepted beat
   // ---------------------------------------------------------------------
   logic                           tbl_live [NumSlots] = '{default: 1'b0};
   logic [lprl_pkg::AddrBits-1:0]  tbl_net  [NumSlots];
   logic [lprl_pkg::AddrBits-1:0]  tbl_mask [NumSlots];
   logic [lprl_pkg::AddrBits-1:0]  tbl_gw   [NumSlots];
   logic [lprl_pkg::IfaceBits-1:0] tbl_port [NumSlots];

   route_answer_type answers_q[$];   // lookups still waiting for their response
   route_req_type    requests_q[$];  // beats not yet offered to the block
   route_req_type    cur_req;        // beat currently on the request bus

   task automatic apply_route_request(input route_req_type r);
      route_answer_type              a;
      logic [lprl_pkg::AddrBits-1:0] best;
      a.found = 1'b0;
      a.next_hop = '0;
      a.out_interface = '0;
      best = '0;
      unique case (r.op)
         lprl_pkg::OP_WRITE: begin
            tbl_live[r.slot] = 1'b1;
            tbl_net[r.slot]  = r.prefix;
            tbl_mask[r.slot] = r.netmask;
            tbl_gw[r.slot]   = r.gateway;
            tbl_port[r.slot] = r.iface;
         end
         lprl_pkg::OP_CLEAR: tbl_live[r.slot] = 1'b0;
         lprl_pkg::OP_LOOKUP: begin
            // strict compare keeps the lowest slot on equal masks
            for (int i = 0; i < NumSlots; i++) begin
               if (tbl_live[i] && ((tbl_net[i] & tbl_mask[i]) == (r.addr & tbl_mask[i]))
                   && (!a.found || tbl_mask[i] > best)) begin
                  a.found = 1'b1;
                  best = tbl_mask[i];
                  a.next_hop = tbl_gw[i];
                  a.out_interface = tbl_port[i];
               end
            end
            answers_q = {answers_q, a};
         end
         default: ;  // reserved op: no state change, no response
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   logic [lprl_pkg::AddrBits-1:0] net_base [4];          // few networks so routes overlap
   logic [lprl_pkg::AddrBits-1:0] gen_net  [NumSlots];   // last route written per slot,
   logic [lprl_pkg::AddrBits-1:0] gen_mask [NumSlots];   // used to aim lookups at it

   function automatic logic [lprl_pkg::AddrBits-1:0] prefix_mask(input int len);
      return (len == 0) ? '0 : 32'hFFFF_FFFF << (32 - len);
   endfunction

   // Fields the op does not use are left random.
   task automatic push_req(input logic [lprl_pkg::OpBits-1:0] op, input int slot,
                           input logic [lprl_pkg::AddrBits-1:0] pfx,
                           input logic [lprl_pkg::AddrBits-1:0] msk,
                           input logic [lprl_pkg::AddrBits-1:0] gw,
                           input logic [lprl_pkg::IfaceBits-1:0] ifc,
                           input logic [lprl_pkg::AddrBits-1:0] addr);
      route_req_type r;
      r.op      = op;
      r.slot    = lprl_pkg::SlotBits'($urandom_range(0, NumSlots - 1));
      r.prefix  = $urandom;
      r.netmask = $urandom;
      r.gateway = $urandom;
      r.iface   = lprl_pkg::IfaceBits'($urandom_range(0, 255));
      r.addr    = $urandom;
      if (op == lprl_pkg::OP_WRITE || op == lprl_pkg::OP_CLEAR)
         r.slot = lprl_pkg::SlotBits'(slot);
      if (op == lprl_pkg::OP_WRITE) begin
         r.prefix  = pfx;
         r.netmask = msk;
         r.gateway = gw;
         r.iface   = ifc;
         gen_net[slot]  = pfx;
         gen_mask[slot] = msk;
      end
      if (op == lprl_pkg::OP_LOOKUP)
         r.addr = addr;
      requests_q = {requests_q, r};
   endtask

   int errors       = 0;
   int answers_seen = 0;

   initial begin
      int                            pick;
      int                            s;
      logic [lprl_pkg::AddrBits-1:0] pfx;
      logic [lprl_pkg::AddrBits-1:0] msk;
      logic [lprl_pkg::AddrBits-1:0] addr;

      for (int k = 0; k < 4; k++)
         net_base[k] = $urandom;
      for (int i = 0; i < NumSlots; i++) begin
         gen_net[i]  = net_base[i % 4];
         gen_mask[i] = '0;
      end

      // Directed part: empty table, default route, host route, ties,
      // longer prefix, non-contiguous mask, clears, reserved op.
      push_req(lprl_pkg::OP_LOOKUP, 0, '0, '0, '0, '0, 32'h0000_0000);
      push_req(lprl_pkg::OP_LOOKUP, 0, '0, '0, '0, '0, 32'hFFFF_FFFF);
      push_req(lprl_pkg::OP_CLEAR, 7, '0, '0, '0, '0, '0);       // clear an empty slot
      push_req(OpReserved, 0, '0, '0, '0, '0, '0);
      push_req(lprl_pkg::OP_WRITE, 15, 32'h0, 32'h0, 32'hFFFF_FFFF, 8'hFF, '0);  // default
      push_req(lprl_pkg::OP_LOOKUP, 0, '0, '0, '0, '0, 32'h1234_5678);
      push_req(lprl_pkg::OP_WRITE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 8'h00, '0);
      push_req(lprl_pkg::OP_LOOKUP, 0, '0, '0, '0, '0, 32'hFFFF_FFFF);   // found, zero hop
      push_req(lprl_pkg::OP_LOOKUP, 0, '0, '0, '0, '0, 32'hFFFF_FFFE);
      push_req(lprl_pkg::OP_WRITE, 3, 32'h0A00_0000, prefix_mask(8), 32'h0A00_00FE,
               8'h03, '0);
      push_req(lprl_pkg::OP_WRITE, 5, 32'h0A00_0000, prefix_mask(8), 32'h0A00_00FD,
               8'h05, '0);
      push_req(lprl_pkg::OP_LOOKUP, 0, '0, '0, '0, '0, 32'h0A12_3456);   // tie, slot 3 wins
      push_req(lprl_pkg::OP_WRITE, 8, 32'h0A12_0000, prefix_mask(16), 32'h0A12_0001,
               8'h08, '0);
      push_req(lprl_pkg::OP_LOOKUP, 0, '0, '0, '0, '0, 32'h0A12_3456);
      // FF00FF00 is numerically below FFFF0000, so the /16 still outranks it
      push_req(lprl_pkg::OP_WRITE, 9, 32'h0A00_3400, 32'hFF00_FF00, 32'hC0A8_0109,
               8'h09, '0);
      push_req(lprl_pkg::OP_LOOKUP, 0, '0, '0, '0, '0, 32'h0A12_3456);
      push_req(lprl_pkg::OP_CLEAR, 3, '0, '0, '0, '0, '0);
      push_req(lprl_pkg::OP_LOOKUP, 0, '0, '0, '0, '0, 32'h0A99_9999);   // falls to slot 5
      push_req(lprl_pkg::OP_CLEAR, 15, '0, '0, '0, '0, '0);
      push_req(lprl_pkg::OP_LOOKUP, 0, '0, '0, '0, '0, 32'h0B00_0000);   // no match
      push_req(lprl_pkg::OP_WRITE, 15, 32'hFFFF_FFFF, 32'h0, 32'h5555_5555, 8'hAA, '0);
      push_req(lprl_pkg::OP_LOOKUP, 0, '0, '0, '0, '0, 32'h0000_0000);
      push_req(OpReserved, 0, '0, '0, '0, '0, '0);
      push_req(lprl_pkg::OP_LOOKUP, 0, '0, '0, '0, '0, 32'hFFFF_FFFF);

      // Random part: mostly routes built on a few shared networks and
      // lookups aimed inside them, plus clears, noise and reserved ops.
      while (requests_q.size() < ItemCount) begin
         pick = $urandom_range(0, 99);
         s = $urandom_range(0, NumSlots - 1);
         if (pick < 30) begin
            if ($urandom_range(0, 9) == 0)
               msk = $urandom;
            else begin
               case ($urandom_range(0, 7))
                  0: msk = prefix_mask(0);
                  1: msk = prefix_mask(8);
                  2: msk = prefix_mask(16);
                  3: msk = prefix_mask(24);
                  4: msk = prefix_mask(32);
                  default: msk = prefix_mask($urandom_range(0, 32));
               endcase
            end
            if ($urandom_range(0, 7) == 0)
               pfx = $urandom;
            else
               pfx = net_base[$urandom_range(0, 3)] ^ ($urandom & ~msk);
            push_req(lprl_pkg::OP_WRITE, s, pfx, msk, $urandom,
                     lprl_pkg::IfaceBits'($urandom_range(0, 255)), '0);
         end else if (pick < 40) begin
            push_req(lprl_pkg::OP_CLEAR, s, '0, '0, '0, '0, '0);
         end else if (pick < 96) begin
            case ($urandom_range(0, 4))
               0: addr = $urandom;
               1: addr = net_base[$urandom_range(0, 3)]
                         ^ ($urandom & (32'hFFFF_FFFF >> $urandom_range(0, 32)));
               default: addr = gen_net[s] ^ ($urandom & ~gen_mask[s]
                                & (32'hFFFF_FFFF >> $urandom_range(8, 32)));
            endcase
            push_req(lprl_pkg::OP_LOOKUP, 0, '0, '0, '0, '0, addr);
         end else begin
            push_req(OpReserved, 0, '0, '0, '0, '0, '0);
         end
      end

      // Single reset at the start, released on a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Let every beat go in, then every lookup come back, then drain
      while (requests_q.size() != 0 || req_tvalid)
         @(posedge clock);
      while (answers_q.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (errors == 0 && answers_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request driver: changes on the falling edge, random idle bursts and
   // idle-free stretches; no idling near the end or during the long hold.
   // ---------------------------------------------------------------------
   bit req_taken = 1'b0;
   int send_gap  = 0;
   int send_calm = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(negedge clock) begin
      int roll;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (requests_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            cur_req = requests_q.pop_front();
            req_tuser  <= cur_req.op;
            req_tdata  <= lprl_pkg::ReqBits'({cur_req.addr, cur_req.iface, cur_req.gateway,
                                              cur_req.netmask, cur_req.prefix,
                                              cur_req.slot});
            req_tvalid <= 1'b1;
            if (requests_q.size() >= TailItems && hold_left == 0) begin
               if (send_calm > 0)
                  send_calm--;
               else begin
                  roll = $urandom_range(0, 19);
                  if (roll < 3)
                     send_gap = $urandom_range(1, 15);
                  else if (roll == 3)
                     send_calm = $urandom_range(30, 120);
               end
            end
         end
      end
      req_taken = 1'b0;
   end

   // Request beat accepted: update the predictor
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         apply_route_request(cur_req);
         req_taken = 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Response side: random stalls, plus one long hold so the chain fills
   // and the block stops taking request beats.
   // ---------------------------------------------------------------------
   int recv_gap  = 0;
   int recv_calm = 0;

   always @(negedge clock) begin
      int roll;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && answers_seen >= HoldAfter) begin
         hold_done = 1'b1;
         hold_left = HoldCycles - 1;
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (requests_q.size() >= TailItems) begin
            if (recv_calm > 0)
               recv_calm--;
            else begin
               roll = $urandom_range(0, 29);
               if (roll < 2)
                  recv_gap = $urandom_range(1, 15);
               else if (roll == 2)
                  recv_calm = $urandom_range(30, 150);
            end
         end
      end
   end

   // Response checker: each beat against the oldest pending lookup
   always @(posedge clock) begin
      route_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         answers_seen++;
         if (answers_q.size() == 0) begin
            errors++;
            if (errors <= ReportLimit)
               $display("%0t: response with no lookup pending: found=%0b hop=%h if=%h",
                        $time, rsp_tuser, rsp_tdata[lprl_pkg::AddrBits-1:0],
                        rsp_tdata[lprl_pkg::AddrBits +: lprl_pkg::IfaceBits]);
         end else begin
            want = answers_q.pop_front();
            if (rsp_tuser !== want.found
                || rsp_tdata[lprl_pkg::AddrBits-1:0] !== want.next_hop
                || rsp_tdata[lprl_pkg::AddrBits +: lprl_pkg::IfaceBits]
                   !== want.out_interface) begin
               errors++;
               if (errors <= ReportLimit)
                  $display({"%0t: lookup mismatch: exp found=%0b hop=%h if=%h, ",
                            "got found=%0b hop=%h if=%h"},
                           $time, want.found, want.next_hop, want.out_interface,
                           rsp_tuser, rsp_tdata[lprl_pkg::AddrBits-1:0],
                           rsp_tdata[lprl_pkg::AddrBits +: lprl_pkg::IfaceBits]);
            end
         end
      end
   end

   // Watchdog: too many cycles with no beat accepted on either side
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= StallLimit) begin
         $display("CHECK FAILED");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

endmodule
